[rtl/sha_pkg.sv]
package sha_pkg;

  localparam int WordW   = 32;
  localparam int CntW    = 3;
  localparam int IdxW    = 3;
  localparam int LenW    = 64;
  localparam int BlkWords = 16;
  localparam int FillW   = $clog2(BlkWords);
  localparam int Rounds  = 64;
  localparam int RndW    = $clog2(Rounds);
  localparam int QueueDepth = 2;
  localparam logic [WordW-1:0] PadWord = 32'h8000_0000;

  // Register map
  localparam logic [1:0] RegHashMode = 2'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_PAD,
    ST_OUT
  } back_state_t;

  // Item as classified by the front end
  typedef struct packed {
    logic [WordW-1:0] word;       // data, with pad byte merged on a short last word
    logic             last;
    logic             full_word;  // four bytes taken
    logic [5:0]       bits;       // bits added to the length
  } item_t;

  function automatic logic [WordW-1:0] ror(input logic [WordW-1:0] x, input int n);
    ror = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic logic [WordW-1:0] bsig0(input logic [WordW-1:0] x);
    bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [WordW-1:0] bsig1(input logic [WordW-1:0] x);
    bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic logic [WordW-1:0] ssig0(input logic [WordW-1:0] x);
    ssig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [WordW-1:0] ssig1(input logic [WordW-1:0] x);
    ssig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [WordW-1:0] init_value(input logic mode, input logic [2:0] i);
    logic [WordW-1:0] v;
    case ({mode, i})
      4'h0: v = 32'h6a09e667;
      4'h1: v = 32'hbb67ae85;
      4'h2: v = 32'h3c6ef372;
      4'h3: v = 32'ha54ff53a;
      4'h4: v = 32'h510e527f;
      4'h5: v = 32'h9b05688c;
      4'h6: v = 32'h1f83d9ab;
      4'h7: v = 32'h5be0cd19;
      4'h8: v = 32'hc1059ed8;
      4'h9: v = 32'h367cd507;
      4'ha: v = 32'h3070dd17;
      4'hb: v = 32'hf70e5939;
      4'hc: v = 32'hffc00b31;
      4'hd: v = 32'h68581511;
      4'he: v = 32'h64f98fa7;
      default: v = 32'hbefa4fa4;
    endcase
    return v;
  endfunction

  function automatic logic [WordW-1:0] round_k(input logic [RndW-1:0] r);
    logic [WordW-1:0] k;
    case (r)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

[rtl/sha256_hash_engine_core.sv]
// SHA-256 / SHA-224 streaming hasher.
// Input queue: drive in_data_word (big-endian), in_byte_count and
// in_last_of_message with push; a transfer happens when push is high and
// full is low. Two items can wait in the input queue.
// A word that does not complete a block is written into the block window.
// The 16th word of a block is absorbed, then 64 rounds run, one a cycle,
// and then the chaining add; meanwhile further words wait in the input queue.
// The last item closes the message: padding is written one word a cycle up
// to the end of the block and one or two more compressions run. The digest
// then appears on the result queue: 8 words for SHA-256, 7 for SHA-224,
// word 0 first, while empty is low; each is a transfer at pop. While the
// receiver stalls the back end holds, and further input waits in the input
// queue.
// hash_mode is written over the APB port at address 0 while idle; it
// reloads the initial values and drops any partial message.
// Reset selects SHA-256, loads its initial values and empties both sides.
module sha256_hash_engine_core #(
  parameter int QueueDepth = sha_pkg::QueueDepth
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  output logic                      full,
  input  logic [sha_pkg::WordW-1:0] in_data_word,
  input  logic [sha_pkg::CntW-1:0]  in_byte_count,
  input  logic                      in_last_of_message,
  output logic                      empty,
  input  logic                      pop,
  output logic [sha_pkg::WordW-1:0] out_digest_word,
  output logic [sha_pkg::IdxW-1:0]  out_word_index,
  output logic                      out_last_word,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [1:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import sha_pkg::*;

  logic  q_valid, q_take, cfg_wr, mode;
  item_t q_item;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == RegHashMode);
  assign prdata = {31'b0, mode};

  sha_front #(.Depth(QueueDepth)) u_front (
    .clk, .rst_n, .push, .full,
    .in_data_word, .in_byte_count, .in_last_of_message,
    .q_valid, .q_item, .q_take
  );

  sha_back u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_take,
    .cfg_wr, .cfg_mode(pwdata[0]), .mode,
    .empty, .pop, .out_digest_word, .out_word_index, .out_last_word
  );

  // Final word is at index 6 (SHA-224) or 7 (SHA-256)
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_last_word |-> (out_word_index == 3'd6 || out_word_index == 3'd7))
    else $error("last digest word at wrong index");

  // Digest run ends after its last transfer
  a_end_run: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !empty && out_last_word |=> empty)
    else $error("result still shown after last word");

  // Words advance one by one
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !empty && !out_last_word |=>
      !empty && out_word_index == $past(out_word_index) + 3'd1)
    else $error("digest word index skipped");

endmodule

[rtl/sha_front.sv]
module sha_front #(
  parameter int Depth = sha_pkg::QueueDepth
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  output logic                     full,
  input  logic [sha_pkg::WordW-1:0] in_data_word,
  input  logic [sha_pkg::CntW-1:0]  in_byte_count,
  input  logic                     in_last_of_message,
  output logic                     q_valid,
  output sha_pkg::item_t           q_item,
  input  logic                     q_take
);
  import sha_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntQW = $clog2(Depth + 1);

  item_t            slot_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CntQW-1:0] count_r;
  item_t            cls;
  logic [2:0]       eff_cnt;
  logic [WordW-1:0] keep_mask;
  logic             wr_en, rd_en;

  // Classify: effective byte count, pad byte merged into a short last word
  always_comb begin
    eff_cnt = (in_last_of_message && in_byte_count < 3'd4) ? in_byte_count : 3'd4;
    keep_mask = ~({WordW{1'b1}} >> {eff_cnt, 3'b000});
    cls.last = in_last_of_message;
    cls.full_word = (eff_cnt == 3'd4);
    cls.bits = {eff_cnt, 3'b000};
    if (eff_cnt == 3'd4) begin
      cls.word = in_data_word;
    end else begin
      cls.word = (in_data_word & keep_mask) | (PadWord >> {eff_cnt, 3'b000});
    end
  end

  assign full    = (count_r == CntQW'(Depth));
  assign q_valid = (count_r != '0);
  assign q_item  = slot_r[rd_ptr_r];
  assign wr_en   = push && !full;
  assign rd_en   = q_take && q_valid;

  // Queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[rtl/sha_back.sv]
module sha_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  sha_pkg::item_t            q_item,
  output logic                      q_take,
  input  logic                      cfg_wr,
  input  logic                      cfg_mode,
  output logic                      mode,
  output logic                      empty,
  input  logic                      pop,
  output logic [sha_pkg::WordW-1:0] out_digest_word,
  output logic [sha_pkg::IdxW-1:0]  out_word_index,
  output logic                      out_last_word
);
  import sha_pkg::*;

  back_state_t       state_r, state_nxt;
  logic              mode_r, mode_nxt;
  logic [WordW-1:0]  chain_r [8];
  logic [WordW-1:0]  chain_nxt [8];
  logic [WordW-1:0]  vars_r [8];
  logic [WordW-1:0]  vars_nxt [8];
  logic [WordW-1:0]  win_r [BlkWords];
  logic [WordW-1:0]  win_nxt [BlkWords];
  logic [LenW-1:0]   len_r, len_nxt;
  logic [FillW-1:0]  fill_r, fill_nxt;
  logic [RndW-1:0]   rnd_r, rnd_nxt;
  logic [IdxW-1:0]   idx_r, idx_nxt;
  logic              closing_r, closing_nxt;
  logic              pending_r, pending_nxt;
  logic              extra_r, extra_nxt;
  logic              done_r, done_nxt;
  logic [WordW-1:0]  t1, t2, w_new, pad_word;
  logic [IdxW-1:0]   last_idx;

  assign mode            = mode_r;
  assign empty           = (state_r != ST_OUT);
  assign out_digest_word = chain_r[idx_r];
  assign out_word_index  = idx_r;
  assign last_idx        = mode_r ? 3'd6 : 3'd7;
  assign out_last_word   = (idx_r == last_idx);

  // Round datapath and schedule extension
  always_comb begin
    t1 = vars_r[7] + bsig1(vars_r[4]) + ((vars_r[4] & vars_r[5]) ^ (~vars_r[4] & vars_r[6]))
       + round_k(rnd_r) + win_r[0];
    t2 = bsig0(vars_r[0])
       + ((vars_r[0] & vars_r[1]) ^ (vars_r[0] & vars_r[2]) ^ (vars_r[1] & vars_r[2]));
    w_new = ssig1(win_r[14]) + win_r[9] + ssig0(win_r[1]) + win_r[0];
  end

  // Padding word for the current fill position
  always_comb begin
    if (pending_r || extra_r) begin
      pad_word = pending_r ? PadWord : '0;
    end else if (fill_r == FillW'(BlkWords - 2)) begin
      pad_word = len_r[63:32];
    end else if (fill_r == FillW'(BlkWords - 1)) begin
      pad_word = len_r[31:0];
    end else begin
      pad_word = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      mode_r    <= 1'b0;
      len_r     <= '0;
      fill_r    <= '0;
      rnd_r     <= '0;
      idx_r     <= '0;
      closing_r <= 1'b0;
      pending_r <= 1'b0;
      extra_r   <= 1'b0;
      done_r    <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= init_value(1'b0, 3'(i));
      end
    end else begin
      state_r   <= state_nxt;
      mode_r    <= mode_nxt;
      len_r     <= len_nxt;
      fill_r    <= fill_nxt;
      rnd_r     <= rnd_nxt;
      idx_r     <= idx_nxt;
      closing_r <= closing_nxt;
      pending_r <= pending_nxt;
      extra_r   <= extra_nxt;
      done_r    <= done_nxt;
      chain_r   <= chain_nxt;
    end
  end

  // Working variables and block window
  always_ff @(posedge clk) begin
    vars_r <= vars_nxt;
    win_r  <= win_nxt;
  end

  // Next state
  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    len_nxt     = len_r;
    fill_nxt    = fill_r;
    rnd_nxt     = rnd_r;
    idx_nxt     = idx_r;
    closing_nxt = closing_r;
    pending_nxt = pending_r;
    extra_nxt   = extra_r;
    done_nxt    = done_r;
    chain_nxt   = chain_r;
    vars_nxt    = vars_r;
    win_nxt     = win_r;
    q_take      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (cfg_wr) begin
          mode_nxt = cfg_mode;
          len_nxt  = '0;
          fill_nxt = '0;
          for (int i = 0; i < 8; i++) begin
            chain_nxt[i] = init_value(cfg_mode, 3'(i));
          end
        end else if (q_valid) begin
          q_take = 1'b1;
          win_nxt[fill_r] = q_item.word;
          fill_nxt = fill_r + 1'b1;
          len_nxt = len_r + LenW'(q_item.bits);
          if (q_item.last) begin
            closing_nxt = 1'b1;
            pending_nxt = q_item.full_word;
            extra_nxt   = !q_item.full_word && (fill_r == FillW'(BlkWords - 2));
          end
          if (fill_r == FillW'(BlkWords - 1)) begin
            vars_nxt  = chain_r;
            rnd_nxt   = '0;
            state_nxt = ST_ROUND;
          end else if (q_item.last) begin
            state_nxt = ST_PAD;
          end
        end
      end

      ST_PAD: begin
        win_nxt[fill_r] = pad_word;
        fill_nxt = fill_r + 1'b1;
        if (pending_r) begin
          pending_nxt = 1'b0;
          extra_nxt   = (fill_r == FillW'(BlkWords - 2));
        end else if (extra_r) begin
          if (fill_r == FillW'(BlkWords - 1)) begin
            extra_nxt = 1'b0;
          end
        end else if (fill_r == FillW'(BlkWords - 1)) begin
          done_nxt = 1'b1;
        end
        if (fill_r == FillW'(BlkWords - 1)) begin
          vars_nxt  = chain_r;
          rnd_nxt   = '0;
          state_nxt = ST_ROUND;
        end
      end

      // One compression round a cycle
      ST_ROUND: begin
        for (int i = 7; i > 0; i--) begin
          vars_nxt[i] = vars_r[i-1];
        end
        vars_nxt[4] = vars_r[3] + t1;
        vars_nxt[0] = t1 + t2;
        for (int i = 0; i < BlkWords - 1; i++) begin
          win_nxt[i] = win_r[i+1];
        end
        win_nxt[BlkWords-1] = w_new;
        rnd_nxt = rnd_r + 1'b1;
        if (rnd_r == RndW'(Rounds - 1)) begin
          state_nxt = ST_FINAL;
        end
      end

      ST_FINAL: begin
        for (int i = 0; i < 8; i++) begin
          chain_nxt[i] = chain_r[i] + vars_r[i];
        end
        if (done_r) begin
          idx_nxt   = '0;
          state_nxt = ST_OUT;
        end else if (closing_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      // Digest words leave one per transfer, then the chain reloads
      ST_OUT: begin
        if (pop) begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r == last_idx) begin
            idx_nxt     = '0;
            len_nxt     = '0;
            fill_nxt    = '0;
            closing_nxt = 1'b0;
            done_nxt    = 1'b0;
            for (int i = 0; i < 8; i++) begin
              chain_nxt[i] = init_value(mode_r, 3'(i));
            end
            state_nxt = ST_IDLE;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
